@@ design/ttcc_pkg.sv @@
`timescale 1ns / 1ps

package ttcc_pkg;

   // Terminal commands
   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Pixel engine actions
   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_DRAW   = 2'd1;
   localparam logic [1:0] ACT_SCROLL = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   // Control characters
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_SPACE     = 8'd32;

   localparam logic [2:0] TAB_SPACES = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] REG_TEXT_COLUMNS = 2'd0;
   localparam logic [1:0] REG_TEXT_ROWS    = 2'd1;
   localparam logic [1:0] REG_COLOR_INDEX  = 2'd2;

   localparam logic [7:0] RESET_COLUMNS = 8'd80;
   localparam logic [7:0] RESET_ROWS    = 8'd25;
   localparam logic [3:0] RESET_COLOR   = 4'd15;

   localparam logic [23:0] PALETTE [16] = '{
      24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
      24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
      24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
      24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
   };

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] char_code;
      logic [7:0] target_row;
      logic [7:0] target_col;
   } item_type;

   typedef struct packed {
      logic [7:0] text_columns;
      logic [7:0] text_rows;
      logic [3:0] color_index;
   } cfg_type;

   // Progress through one word: a scroll still owed, spaces drawn so far
   typedef struct packed {
      logic       scroll_pending;
      logic [2:0] drawn;
   } seq_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
      logic [7:0]  glyph;
      logic [23:0] rgb;
      logic [7:0]  cursor_row_now;
      logic [7:0]  cursor_col_now;
      logic        last;
   } result_type;

endpackage

@@ design/ttcc_csr.sv @@
`timescale 1ns / 1ps

module ttcc_csr
   import ttcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data,
   output cfg_type    cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_columns <= RESET_COLUMNS;
         cfg_ff.text_rows    <= RESET_ROWS;
         cfg_ff.color_index  <= RESET_COLOR;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_TEXT_COLUMNS: cfg_ff.text_columns <= csr_write_data;
            REG_TEXT_ROWS:    cfg_ff.text_rows    <= csr_write_data;
            REG_COLOR_INDEX:  cfg_ff.color_index  <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/ttcc_step.sv @@
`timescale 1ns / 1ps

module ttcc_step
   import ttcc_pkg::*;
#(
   parameter int GLYPH_WIDTH  = 8,
   parameter int GLYPH_HEIGHT = 8
) (
   input  item_type   item,
   input  cfg_type    cfg,
   input  seq_type    seq,
   input  logic [7:0] cur_row,
   input  logic [7:0] cur_col,
   output result_type result,
   output seq_type    seq_next,
   output logic [7:0] row_next,
   output logic [7:0] col_next,
   output logic       done
);

   logic        initialised;
   logic [8:0]  row_inc;
   logic [8:0]  col_inc;
   logic        row_wrap;
   logic        col_wrap;
   logic [7:0]  last_row;
   logic [7:0]  col_dec;
   logic [7:0]  glyph_code;
   logic [2:0]  spaces_total;
   logic [2:0]  drawn_inc;
   logic [12:0] px_full;
   logic [12:0] py_full;
   logic [12:0] px_back_full;

   assign initialised  = (cfg.text_columns != 8'd0) && (cfg.text_rows != 8'd0);
   assign row_inc      = {1'b0, cur_row} + 9'd1;
   assign col_inc      = {1'b0, cur_col} + 9'd1;
   assign row_wrap     = row_inc >= {1'b0, cfg.text_rows};
   assign col_wrap     = col_inc >= {1'b0, cfg.text_columns};
   assign last_row     = cfg.text_rows - 8'd1;
   assign col_dec      = cur_col - 8'd1;
   assign glyph_code   = (item.char_code == CHAR_TAB) ? CHAR_SPACE : item.char_code;
   assign spaces_total = (item.char_code == CHAR_TAB) ? TAB_SPACES : 3'd1;
   assign drawn_inc    = seq.drawn + 3'd1;
   assign px_full      = {5'd0, cur_col} * 13'(GLYPH_WIDTH);
   assign py_full      = {5'd0, cur_row} * 13'(GLYPH_HEIGHT);
   assign px_back_full = {5'd0, col_dec} * 13'(GLYPH_WIDTH);

   always_comb begin
      result   = '0;
      seq_next = seq;
      row_next = cur_row;
      col_next = cur_col;
      done     = 1'b1;
      result.action = ACT_NONE;

      if (seq.scroll_pending) begin
         // scroll owed by the previous draw; cursor already moved
         result.action           = ACT_SCROLL;
         seq_next.scroll_pending = 1'b0;
         done                    = (seq.drawn == spaces_total);
      end else begin
         unique case (item.command)
            CMD_PUT: begin
               if (initialised) begin
                  priority if (item.char_code == CHAR_NEWLINE) begin
                     col_next = 8'd0;
                     if (row_wrap) begin
                        row_next      = last_row;
                        result.action = ACT_SCROLL;
                     end else begin
                        row_next = row_inc[7:0];
                     end
                  end else if (item.char_code == CHAR_BACKSPACE) begin
                     if (cur_col != 8'd0) begin
                        col_next       = col_dec;
                        result.action  = ACT_DRAW;
                        result.pixel_x = px_back_full[10:0];
                        result.pixel_y = py_full[10:0];
                        result.glyph   = CHAR_SPACE;
                     end
                  end else begin
                     result.action  = ACT_DRAW;
                     result.pixel_x = px_full[10:0];
                     result.pixel_y = py_full[10:0];
                     result.glyph   = glyph_code;
                     result.rgb     = PALETTE[cfg.color_index];
                     seq_next.drawn = drawn_inc;
                     if (col_wrap) begin
                        col_next = 8'd0;
                        if (row_wrap) begin
                           row_next                = last_row;
                           seq_next.scroll_pending = 1'b1;
                        end else begin
                           row_next = row_inc[7:0];
                        end
                     end else begin
                        col_next = col_inc[7:0];
                     end
                     done = !(col_wrap && row_wrap) && (drawn_inc == spaces_total);
                  end
               end
            end
            CMD_SET: begin
               if (item.target_row < cfg.text_rows) row_next = item.target_row;
               if (item.target_col < cfg.text_columns) col_next = item.target_col;
            end
            CMD_CLEAR: begin
               if (initialised) begin
                  row_next      = 8'd0;
                  col_next      = 8'd0;
                  result.action = ACT_CLEAR;
               end
            end
            default: ;
         endcase
      end

      result.cursor_row_now = row_next;
      result.cursor_col_now = col_next;
      result.last           = done;
   end

endmodule

@@ design/text_terminal_cursor_controller_core.sv @@
`timescale 1ns / 1ps

// Channel   Ports                              Word
// -------   --------------------------------   ------------------------------------
// req       req_valid / req_ready              terminal command, one word per item
// rsp       rsp_valid / rsp_ready              pixel engine command, 1 to 8 words
// csr       csr_write_enable / csr_index       register write, taken at once
//
// One word leaves per cycle while rsp is ready; the words an item causes are
// 1 for most commands, 2 for a draw that scrolls, 4 to 8 for a tab.
// A new item enters in the cycle its predecessor's final word is loaded.
// Synchronous active-high reset clears cursor, progress and valids and restores
// 80 columns, 25 rows and palette index 15.
// A stalled rsp holds its word and the item in progress; req then stalls.

module text_terminal_cursor_controller_core
   import ttcc_pkg::*;
#(
   parameter int GLYPH_WIDTH  = 8,
   parameter int GLYPH_HEIGHT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_target_row,
   input  logic [7:0]  req_target_col,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [10:0] rsp_pixel_x,
   output logic [10:0] rsp_pixel_y,
   output logic [7:0]  rsp_glyph,
   output logic [23:0] rsp_rgb,
   output logic [7:0]  rsp_cursor_row_now,
   output logic [7:0]  rsp_cursor_col_now,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   logic       item_valid_in;
   seq_type    seq_ff;
   seq_type    seq_in;
   seq_type    seq_step;
   logic [7:0] row_ff;
   logic [7:0] col_ff;
   logic [7:0] row_step;
   logic [7:0] col_step;
   result_type result_step;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       step_done;
   logic       out_load;
   logic       step_fire;
   logic       req_fire;

   ttcc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ttcc_step #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT)
   ) u_step (
      .item       (item_ff),
      .cfg        (cfg),
      .seq        (seq_ff),
      .cur_row    (row_ff),
      .cur_col    (col_ff),
      .result     (result_step),
      .seq_next   (seq_step),
      .row_next   (row_step),
      .col_next   (col_step),
      .done       (step_done)
   );

   // The result register frees when empty or when its word is taken
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign step_fire = item_valid_ff && out_load;
   assign req_ready = !item_valid_ff || (step_fire && step_done);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      item_valid_in = item_valid_ff;
      seq_in        = seq_ff;
      if (step_fire) begin
         seq_in = seq_step;
         if (step_done) item_valid_in = 1'b0;
      end
      // a fresh item starts with nothing drawn and no scroll owed
      if (req_fire) begin
         item_valid_in = 1'b1;
         seq_in        = '0;
      end
      rsp_valid_in = out_load ? item_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         seq_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         row_ff        <= 8'd0;
         col_ff        <= 8'd0;
      end else begin
         item_valid_ff <= item_valid_in;
         seq_ff        <= seq_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (step_fire) begin
            row_ff <= row_step;
            col_ff <= col_step;
         end
      end
   end

   // Payload registers: capture the item word and the result word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.command    <= req_command;
         item_ff.char_code  <= req_char_code;
         item_ff.target_row <= req_target_row;
         item_ff.target_col <= req_target_col;
      end
      if (step_fire) rsp_ff <= result_step;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_ff.action;
   assign rsp_pixel_x        = rsp_ff.pixel_x;
   assign rsp_pixel_y        = rsp_ff.pixel_y;
   assign rsp_glyph          = rsp_ff.glyph;
   assign rsp_rgb            = rsp_ff.rgb;
   assign rsp_cursor_row_now = rsp_ff.cursor_row_now;
   assign rsp_cursor_col_now = rsp_ff.cursor_col_now;
   assign rsp_last           = rsp_ff.last;

`ifndef SYNTHESIS
   // A scroll always leaves the cursor at column zero
   a_scroll_col_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.action == ACT_SCROLL) |-> (rsp_ff.cursor_col_now == 8'd0))
      else $error("scroll word with nonzero cursor column");

   // An owed scroll belongs to a live item whose waiting draw is not final
   a_scroll_owed: assert property (@(posedge clock) disable iff (reset)
      seq_ff.scroll_pending |-> (item_valid_ff && rsp_valid_ff && !rsp_ff.last))
      else $error("scroll owed without a live item and a non-final draw");

   // A tab never draws more than four spaces
   a_drawn_bound: assert property (@(posedge clock) disable iff (reset)
      seq_ff.drawn <= TAB_SPACES)
      else $error("space count past a tab's width");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");
`endif

endmodule

@@ verif/terminal_command_checker.sv @@
`timescale 1ns / 1ps

module terminal_command_checker
   import ttcc_pkg::*;
#(
   parameter int GLYPH_WIDTH  = 8,
   parameter int GLYPH_HEIGHT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_target_row,
   input  logic [7:0]  req_target_col,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_action,
   input  logic [10:0] rsp_pixel_x,
   input  logic [10:0] rsp_pixel_y,
   input  logic [7:0]  rsp_glyph,
   input  logic [23:0] rsp_rgb,
   input  logic [7:0]  rsp_cursor_row_now,
   input  logic [7:0]  rsp_cursor_col_now,
   input  logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data,
   output int          mismatches,
   output int          pending_words
);

   localparam logic [23:0] ERASE_RGB  = 24'h000000;
   localparam int          REPORT_CAP = 40;

   result_type expected_cmds[$];
   logic [7:0] text_cols;
   logic [7:0] text_rows;
   logic [3:0] color_sel;
   logic [7:0] cur_row;
   logic [7:0] cur_col;
   int         fail_count = 0;
   int         word_count = 0;

   task automatic report(input string msg);
      fail_count++;
      if (fail_count <= REPORT_CAP) begin
         $display("%0t ns, word %0d: %s", $time, word_count, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   // Queue one pixel engine word carrying the cursor as it stands now.
   task automatic push_word(input logic [1:0] act, input int px, input int py,
                            input logic [7:0] glyph, input logic [23:0] rgb);
      result_type w;
      w.action         = act;
      w.pixel_x        = 11'(px);
      w.pixel_y        = 11'(py);
      w.glyph          = glyph;
      w.rgb            = rgb;
      w.cursor_row_now = cur_row;
      w.cursor_col_now = cur_col;
      w.last           = 1'b0;
      expected_cmds.push_back(w);
   endtask

   task automatic next_text_row(output bit scrolled);
      if (int'(cur_row) + 1 >= int'(text_rows)) begin
         cur_row  = text_rows - 8'd1;
         cur_col  = '0;
         scrolled = 1'b1;
      end else begin
         cur_row  = cur_row + 8'd1;
         scrolled = 1'b0;
      end
   endtask

   task automatic draw_and_advance(input logic [7:0] ch);
      int px;
      int py;
      bit scrolled;
      px       = int'(cur_col) * GLYPH_WIDTH;
      py       = int'(cur_row) * GLYPH_HEIGHT;
      scrolled = 1'b0;
      if (int'(cur_col) + 1 >= int'(text_cols)) begin
         cur_col = '0;
         next_text_row(scrolled);
      end else begin
         cur_col = cur_col + 8'd1;
      end
      push_word(ACT_DRAW, px, py, ch, PALETTE[color_sel]);
      if (scrolled) begin
         push_word(ACT_SCROLL, 0, 0, 8'd0, 24'd0);
      end
   endtask

   task automatic predict_pixel_cmds(input logic [1:0] cmd, input logic [7:0] ch,
                                     input logic [7:0] trow, input logic [7:0] tcol);
      int         queued;
      bit         active;
      bit         scrolled;
      result_type tail;
      queued = expected_cmds.size();
      active = (text_cols != 8'd0) && (text_rows != 8'd0);
      if (cmd == CMD_PUT && active) begin
         if (ch == CHAR_NEWLINE) begin
            cur_col = '0;
            next_text_row(scrolled);
            if (scrolled) begin
               push_word(ACT_SCROLL, 0, 0, 8'd0, 24'd0);
            end
         end else if (ch == CHAR_BACKSPACE) begin
            if (cur_col != 8'd0) begin
               cur_col = cur_col - 8'd1;
               push_word(ACT_DRAW, int'(cur_col) * GLYPH_WIDTH,
                         int'(cur_row) * GLYPH_HEIGHT, CHAR_SPACE, ERASE_RGB);
            end
         end else if (ch == CHAR_TAB) begin
            repeat (TAB_SPACES) draw_and_advance(CHAR_SPACE);
         end else begin
            draw_and_advance(ch);
         end
      end else if (cmd == CMD_SET) begin
         if (trow < text_rows) cur_row = trow;
         if (tcol < text_cols) cur_col = tcol;
      end else if (cmd == CMD_CLEAR && active) begin
         cur_row = '0;
         cur_col = '0;
         push_word(ACT_CLEAR, 0, 0, 8'd0, 24'd0);
      end
      if (expected_cmds.size() == queued) begin
         push_word(ACT_NONE, 0, 0, 8'd0, 24'd0);
      end
      tail      = expected_cmds.pop_back();
      tail.last = 1'b1;
      expected_cmds.push_back(tail);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         text_cols = RESET_COLUMNS;
         text_rows = RESET_ROWS;
         color_sel = RESET_COLOR;
         cur_row   = '0;
         cur_col   = '0;
         expected_cmds.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_TEXT_COLUMNS: text_cols = csr_write_data;
               REG_TEXT_ROWS:    text_rows = csr_write_data;
               REG_COLOR_INDEX:  color_sel = csr_write_data[3:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_pixel_cmds(req_command, req_char_code, req_target_row, req_target_col);
         end
         if (rsp_valid && rsp_ready) begin
            word_count++;
            if (expected_cmds.size() == 0) begin
               report("result word arrived with none expected");
            end else begin
               want = expected_cmds.pop_front();
               check_field("action", rsp_action, want.action);
               check_field("pixel_x", rsp_pixel_x, want.pixel_x);
               check_field("pixel_y", rsp_pixel_y, want.pixel_y);
               check_field("glyph", rsp_glyph, want.glyph);
               check_field("rgb", rsp_rgb, want.rgb);
               check_field("cursor_row_now", rsp_cursor_row_now, want.cursor_row_now);
               check_field("cursor_col_now", rsp_cursor_col_now, want.cursor_col_now);
               check_field("last", rsp_last, want.last);
            end
         end
      end
      pending_words <= expected_cmds.size();
      mismatches    <= fail_count;
   end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import ttcc_pkg::*;

   localparam int         GLYPH_WIDTH     = 8;
   localparam int         GLYPH_HEIGHT    = 8;
   // An item yields at most eight words, one per cycle while rsp_ready is high; this is ample slack.
   localparam int         SETTLE_CYCLES   = 16;
   localparam int         HOLD_OFF_CYCLES = 250;
   localparam int         CYCLE_LIMIT     = 300000;
   localparam int         RANDOM_ITEMS    = 15;
   localparam logic [1:0] CMD_UNUSED      = 2'd3;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command      = CMD_PUT;
   logic [7:0]  req_char_code    = '0;
   logic [7:0]  req_target_row   = '0;
   logic [7:0]  req_target_col   = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [1:0]  rsp_action;
   logic [10:0] rsp_pixel_x;
   logic [10:0] rsp_pixel_y;
   logic [7:0]  rsp_glyph;
   logic [23:0] rsp_rgb;
   logic [7:0]  rsp_cursor_row_now;
   logic [7:0]  rsp_cursor_col_now;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index        = REG_TEXT_COLUMNS;
   logic [7:0]  csr_write_data   = '0;

   int          mismatches;
   int          pending_words;
   int          send_gap_pct     = 15;
   int          rsp_stall_pct    = 70;
   int          rsp_hold_cycles  = 0;
   int          cycle_count      = 0;
   // Shadow of the terminal size, used only to shape stimulus.
   logic [7:0]  term_cols        = RESET_COLUMNS;
   logic [7:0]  term_rows        = RESET_ROWS;

   text_terminal_cursor_controller_core #(
      .GLYPH_WIDTH (GLYPH_WIDTH),
      .GLYPH_HEIGHT(GLYPH_HEIGHT)
   ) dut (.*);

   terminal_command_checker #(
      .GLYPH_WIDTH (GLYPH_WIDTH),
      .GLYPH_HEIGHT(GLYPH_HEIGHT)
   ) checker_i (.*);

   always #5 clock = ~clock;

   // Bound the run: a hung handshake or lost word ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Result side: stall at random, or hold off for a long stretch on request
   // so that the block backs up and stalls its input.
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            hold            = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one command word and hold it until taken. Valid stays high on
   // return so a back-to-back word never drops it within one step.
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
                            input logic [7:0] trow, input logic [7:0] tcol);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_char_code  <= ch;
      req_target_row <= trow;
      req_target_col <= tcol;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic put_char(input logic [7:0] ch);
      send_item(CMD_PUT, ch, 8'($urandom), 8'($urandom));
   endtask

   task automatic set_cursor(input logic [7:0] trow, input logic [7:0] tcol);
      send_item(CMD_SET, 8'($urandom), trow, tcol);
   endtask

   // Stop offering, wait for every predicted word, then let the block settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Reprogram all three registers on an idle block, one per cycle.
   task automatic set_terminal(input logic [7:0] cols, input logic [7:0] rows,
                               input logic [3:0] color);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index        <= REG_TEXT_COLUMNS;
      csr_write_data   <= cols;
      @(posedge clock);
      csr_index        <= REG_TEXT_ROWS;
      csr_write_data   <= rows;
      @(posedge clock);
      csr_index        <= REG_COLOR_INDEX;
      csr_write_data   <= {4'd0, color};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      term_cols = cols;
      term_rows = rows;
   endtask

   // Mostly small sizes so wraps and scrolls come often; sometimes the extremes.
   function automatic logic [7:0] pick_size(input int top_size);
      case ($urandom_range(9))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd1;
         default: return 8'($urandom_range(top_size, 2));
      endcase
   endfunction

   // Send random commands until n of them do something; commands the block
   // drops (unused code, put or clear while uninitialized) do not count.
   task automatic send_random(input int n);
      int         taken;
      int         pick;
      logic [1:0] cmd;
      logic [7:0] ch;
      logic [7:0] trow;
      logic [7:0] tcol;
      taken = 0;
      while (taken < n) begin
         pick = $urandom_range(99);
         if (pick < 60) cmd = CMD_PUT;
         else if (pick < 88) cmd = CMD_SET;
         else if (pick < 94) cmd = CMD_CLEAR;
         else cmd = CMD_UNUSED;
         pick = $urandom_range(99);
         if (pick < 10) ch = CHAR_NEWLINE;
         else if (pick < 18) ch = CHAR_TAB;
         else if (pick < 25) ch = CHAR_BACKSPACE;
         else ch = 8'($urandom_range(255));
         // Half the targets sit in range or just at the edge, half anywhere.
         if ($urandom_range(1) == 1) begin
            trow = 8'($urandom_range(term_rows));
            tcol = 8'($urandom_range(term_cols));
         end else begin
            trow = 8'($urandom);
            tcol = 8'($urandom);
         end
         send_item(cmd, ch, trow, tcol);
         if (cmd == CMD_SET ||
             (cmd != CMD_UNUSED && term_cols != 8'd0 && term_rows != 8'd0)) begin
            taken++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset size 80x25, white ink.
      put_char(8'h41);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(CHAR_BACKSPACE);        // erase the last cell drawn
      put_char(CHAR_TAB);
      put_char(CHAR_NEWLINE);          // mid-screen: no scroll
      set_cursor(8'd24, 8'd79);
      put_char(8'h5A);                 // bottom-right: wrap and scroll
      put_char(CHAR_NEWLINE);          // on the last row: scroll
      put_char(CHAR_BACKSPACE);        // at column zero: nothing
      set_cursor(8'd255, 8'd255);      // both out of range: kept
      set_cursor(8'd24, 8'd77);
      put_char(CHAR_TAB);              // wraps and scrolls inside the tab
      set_cursor(8'd3, 8'd200);        // row taken, column kept
      send_item(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
      send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));

      // One cell terminal, black ink: every space of a tab scrolls.
      set_terminal(8'd1, 8'd1, 4'd0);
      put_char(CHAR_TAB);
      put_char(8'h7E);
      put_char(CHAR_NEWLINE);

      // Zero columns: put and clear drop, set cursor takes only the row.
      set_terminal(8'd0, 8'd25, 4'd9);
      put_char(8'h71);
      send_item(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
      set_cursor(8'd5, 8'd0);

      // Park the cursor far out, then shrink the screen under it.
      set_terminal(8'd255, 8'd255, 4'd6);
      set_cursor(8'd254, 8'd254);
      set_terminal(8'd10, 8'd5, 4'd1);
      put_char(8'h62);

      // Zero rows: tab drops, set cursor takes only the column.
      set_terminal(8'd255, 8'd0, 4'd15);
      set_cursor(8'd0, 8'd0);
      put_char(CHAR_TAB);

      // Random: receiver stalls hard, with one long hold-off up front.
      set_terminal(8'd3, 8'd2, 4'd12);
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      send_random(RANDOM_ITEMS);
      set_terminal(pick_size(12), pick_size(6), 4'($urandom_range(15)));
      send_random(RANDOM_ITEMS);

      // Swap: sender gaps often, receiver mostly ready.
      send_gap_pct  = 70;
      rsp_stall_pct = 15;
      set_terminal(pick_size(12), pick_size(6), 4'($urandom_range(15)));
      send_random(RANDOM_ITEMS);
      set_terminal(pick_size(12), pick_size(6), 4'($urandom_range(15)));
      send_random(RANDOM_ITEMS);

      // Full rate both ways.
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      set_terminal(pick_size(12), pick_size(6), 4'($urandom_range(15)));
      send_random(RANDOM_ITEMS);

      drain_results();
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
